FILE: sv/salc_pkg.sv
// Shared types, widths and defaults for the set-associative LRU tag store.
// No dependencies; every other file of the block imports this package.
package salc_pkg;

   localparam int KIND_W       = 2;
   localparam int SET_IDX_W    = 6;
   localparam int TAG_W        = 20;
   localparam int OUTCOME_W    = 2;
   localparam int TOTAL_W      = 32;
   localparam int STAMP_W      = 48;
   localparam int WAYS_CFG_W   = 4;

   // Widest set index and tag that the parameters allow.
   localparam int SET_EXT_W    = 12;
   localparam int TAG_EXT_W    = 58;

   localparam int DEF_SET_BITS = 6;
   localparam int DEF_WAYS     = 8;
   localparam int DEF_TAG_BITS = 20;

   localparam logic [WAYS_CFG_W-1:0] WAYS_RESET = 4'd8;

   typedef enum logic [KIND_W-1:0] {
      KIND_FETCH,
      KIND_LOAD,
      KIND_STORE,
      KIND_MODIFY
   } kind_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OUT_NONE,
      OUT_HIT,
      OUT_COLD,
      OUT_CONFLICT
   } outcome_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_SELECT,
      ST_FINISH
   } salc_state_type;

endpackage

FILE: sv/salc_if.sv
// Valid/ready channel interfaces of the tag store: requests, responses, config.
// Depends on salc_pkg for the field widths.
interface salc_req_if;
   import salc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [KIND_W-1:0]    kind;
   logic [SET_IDX_W-1:0] set_index;
   logic [TAG_W-1:0]     tag;

   modport source (output valid, kind, set_index, tag, input ready);
   modport sink (input valid, kind, set_index, tag, output ready);
endinterface

interface salc_rsp_if;
   import salc_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [OUTCOME_W-1:0] outcome;
   logic                 second_hit;
   logic [TOTAL_W-1:0]   hit_total;
   logic [TOTAL_W-1:0]   cold_miss_total;
   logic [TOTAL_W-1:0]   conflict_miss_total;
   logic [TOTAL_W-1:0]   eviction_total;

   modport source (output valid, outcome, second_hit, hit_total, cold_miss_total,
                   conflict_miss_total, eviction_total, input ready);
   modport sink (input valid, outcome, second_hit, hit_total, cold_miss_total,
                 conflict_miss_total, eviction_total, output ready);
endinterface

interface salc_csr_if;
   import salc_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [WAYS_CFG_W-1:0] ways_in_use;

   modport source (output valid, ways_in_use, input ready);
   modport sink (input valid, ways_in_use, output ready);
endinterface

FILE: sv/salc_tag_ram.sv
// Set-row memory of the tag store: one write port, one read port, registered read.
// Depends on salc_pkg for the default parameter values; widths come from the parameters.
module salc_tag_ram #(
   parameter int AW    = salc_pkg::DEF_SET_BITS,
   parameter int ROW_W = salc_pkg::DEF_WAYS * (1 + salc_pkg::DEF_TAG_BITS + salc_pkg::STAMP_W)
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [ROW_W-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [ROW_W-1:0] wr_data
);
   import salc_pkg::*;

   logic [ROW_W-1:0] mem [2**AW];
   logic [ROW_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read, so the row stays available for the update.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/salc_lru_sel.sv
// Iterative LRU victim search: halves the candidate list once per cycle.
// Depends on salc_pkg for the stamp width.
module salc_lru_sel #(
   parameter int WAYS = salc_pkg::DEF_WAYS,
   parameter int WIW  = (WAYS > 1) ? $clog2(WAYS) : 1
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic [WAYS-1:0]                        in_use,
   input  logic [WAYS-1:0][salc_pkg::STAMP_W-1:0] stamps,
   output logic                                   done,
   output logic [WIW-1:0]                         way
);
   import salc_pkg::*;

   localparam int LVL = (WAYS > 1) ? $clog2(WAYS) : 0;
   localparam int P   = 1 << LVL;
   localparam int CW  = (LVL > 0) ? $clog2(LVL + 1) : 1;

   logic [P-1:0]              load_v;
   logic [P-1:0][STAMP_W-1:0] load_s;
   logic [P-1:0][WIW-1:0]     load_i;

   logic [P-1:0]              cand_v_ff, cand_v_in;
   logic [P-1:0][STAMP_W-1:0] cand_s_ff, cand_s_in;
   logic [P-1:0][WIW-1:0]     cand_i_ff, cand_i_in;
   logic                      busy_ff, busy_in;
   logic [CW-1:0]             cnt_ff, cnt_in;

   for (genvar j = 0; j < P; j++) begin : g_load
      if (j < WAYS) begin : g_real
         assign load_v[j] = in_use[j];
         assign load_s[j] = stamps[j];
      end else begin : g_pad
         assign load_v[j] = 1'b0;
         assign load_s[j] = '0;
      end
      assign load_i[j] = WIW'(j);
   end

   assign done = busy_ff && (cnt_ff == CW'(LVL));
   assign way  = cand_i_ff[0];

   always_comb begin
      cand_v_in = cand_v_ff;
      cand_s_in = cand_s_ff;
      cand_i_in = cand_i_ff;
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      if (start) begin
         cand_v_in = load_v;
         cand_s_in = load_s;
         cand_i_in = load_i;
         busy_in   = 1'b1;
         cnt_in    = '0;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         // The lower entry of each pair wins ties, which keeps the lowest way.
         for (int j = 0; j < P / 2; j++) begin
            if (cand_v_ff[2*j+1] &&
                (!cand_v_ff[2*j] || cand_s_ff[2*j+1] < cand_s_ff[2*j])) begin
               cand_v_in[j] = cand_v_ff[2*j+1];
               cand_s_in[j] = cand_s_ff[2*j+1];
               cand_i_in[j] = cand_i_ff[2*j+1];
            end else begin
               cand_v_in[j] = cand_v_ff[2*j];
               cand_s_in[j] = cand_s_ff[2*j];
               cand_i_in[j] = cand_i_ff[2*j];
            end
         end
         for (int j = P / 2; j < P; j++) begin
            cand_v_in[j] = 1'b0;
         end
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      cand_v_ff <= cand_v_in;
      cand_s_ff <= cand_s_in;
      cand_i_ff <= cand_i_in;
   end

endmodule

FILE: sv/set_assoc_lru_cache_tag_model.sv
// Set-associative LRU tag store. A fetch, hit or cold miss passes from idle through the lookup
// and finish states; the result beat is registered, and the next request beat is taken in idle.
// A conflict miss adds an LRU search state between lookup and finish.
// A result beat still waiting at the write-back step holds the block until it is taken.
// Synchronous reset clears control state and then sweeps all 2^SET_BITS rows of the row
// memory to clear the valid bits; no request beat is taken during the sweep.
module set_assoc_lru_cache_tag_model #(
   parameter int SET_BITS = salc_pkg::DEF_SET_BITS,
   parameter int WAYS     = salc_pkg::DEF_WAYS,
   parameter int TAG_BITS = salc_pkg::DEF_TAG_BITS
) (
   input  logic       clock,
   input  logic       reset,
   salc_req_if.sink   req_ch,
   salc_rsp_if.source rsp_ch,
   salc_csr_if.sink   csr_ch
);
   import salc_pkg::*;

   localparam int AW       = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int NUM_SETS = 1 << SET_BITS;
   localparam int WIW      = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ROW_W    = WAYS * (1 + TAG_BITS + STAMP_W);
   localparam int UW       = WAYS_CFG_W + 1;

   function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                  input logic [1:0] b);
      logic [TOTAL_W:0] s;
      s = {1'b0, a} + (TOTAL_W + 1)'(b);
      return s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
   endfunction

   salc_state_type         state_ff, state_in;
   logic [WAYS_CFG_W-1:0]  ways_ff, ways_in;
   logic [AW-1:0]          clr_cnt_ff, clr_cnt_in;
   kind_type               kind_ff, kind_in;
   logic [AW-1:0]          set_ff, set_in;
   logic [TAG_BITS-1:0]    tag_ff, tag_in;
   logic                   hit_ff, hit_in;
   logic [WIW-1:0]         hit_way_ff, hit_way_in;
   logic                   inv_ff, inv_in;
   logic [WIW-1:0]         inv_way_ff, inv_way_in;
   logic [WIW-1:0]         victim_ff, victim_in;
   logic [STAMP_W-1:0]     acc_ff, acc_in;
   logic [TOTAL_W-1:0]     hit_tot_ff, hit_tot_in;
   logic [TOTAL_W-1:0]     cold_tot_ff, cold_tot_in;
   logic [TOTAL_W-1:0]     conf_tot_ff, conf_tot_in;
   logic [TOTAL_W-1:0]     evict_tot_ff, evict_tot_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   outcome_type            outcome_ff, outcome_in;
   logic                   second_ff, second_in;

   logic [SET_EXT_W-1:0]   set_ext;
   logic [TAG_EXT_W-1:0]   tag_ext;
   logic [AW-1:0]          req_set;

   logic                   rd_en;
   logic [ROW_W-1:0]       rd_row;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [ROW_W-1:0]       wr_row;

   logic [WAYS-1:0]                row_valid;
   logic [WAYS-1:0][TAG_BITS-1:0]  row_tag;
   logic [WAYS-1:0][STAMP_W-1:0]   row_stamp;
   logic [WAYS-1:0]                new_valid;
   logic [WAYS-1:0][TAG_BITS-1:0]  new_tag;
   logic [WAYS-1:0][STAMP_W-1:0]   new_stamp;

   logic [UW-1:0]          used;
   logic [WAYS-1:0]        in_use;
   logic [WAYS-1:0]        match;
   logic [WAYS-1:0]        inv;
   logic                   hit_c;
   logic                   inv_c;
   logic [WIW-1:0]         hit_way_c;
   logic [WIW-1:0]         inv_way_c;
   logic                   sel_start;
   logic                   sel_done;
   logic [WIW-1:0]         sel_way;

   logic [WIW-1:0]         line_way;
   logic [2:0]             acc_inc;
   logic [STAMP_W-1:0]     new_acc;
   logic                   push_ok;
   logic                   is_modify;
   logic [1:0]             hit_inc;

   assign set_ext = SET_EXT_W'(req_ch.set_index);
   assign tag_ext = TAG_EXT_W'(req_ch.tag);
   assign req_set = set_ext[AW-1:0] & AW'(NUM_SETS - 1);

   assign {row_stamp, row_tag, row_valid} = rd_row;

   // Way count in use, clamped to 1..WAYS.
   always_comb begin
      if (ways_ff == '0) begin
         used = UW'(1);
      end else if ({1'b0, ways_ff} > UW'(WAYS)) begin
         used = UW'(WAYS);
      end else begin
         used = {1'b0, ways_ff};
      end
      for (int i = 0; i < WAYS; i++) begin
         in_use[i] = UW'(i) < used;
      end
   end

   // Tag compare across the row; the lowest matching way hits, the highest invalid way fills.
   always_comb begin
      hit_way_c = '0;
      inv_way_c = '0;
      for (int i = 0; i < WAYS; i++) begin
         match[i] = in_use[i] && row_valid[i] && (row_tag[i] == tag_ff);
         inv[i]   = in_use[i] && !row_valid[i];
      end
      for (int i = WAYS - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_way_c = WIW'(i);
         end
      end
      for (int i = 0; i < WAYS; i++) begin
         if (inv[i]) begin
            inv_way_c = WIW'(i);
         end
      end
      hit_c = |match;
      inv_c = |inv;
   end

   assign sel_start = (state_ff == ST_LOOKUP) && (kind_ff != KIND_FETCH) && !hit_c && !inv_c;

   salc_lru_sel #(
      .WAYS (WAYS),
      .WIW  (WIW)
   ) u_lru_sel (
      .clock  (clock),
      .reset  (reset),
      .start  (sel_start),
      .in_use (in_use),
      .stamps (row_stamp),
      .done   (sel_done),
      .way    (sel_way)
   );

   // Updated row: the chosen line becomes valid with the request tag and the final stamp.
   assign is_modify = (kind_ff == KIND_MODIFY);
   assign line_way  = hit_ff ? hit_way_ff : (inv_ff ? inv_way_ff : victim_ff);
   assign acc_inc   = (hit_ff ? 3'd1 : 3'd3) + (is_modify ? 3'd1 : 3'd0);
   assign new_acc   = acc_ff + STAMP_W'(acc_inc);
   assign hit_inc   = {1'b0, hit_ff} + {1'b0, is_modify};
   assign push_ok   = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      new_valid           = row_valid;
      new_tag             = row_tag;
      new_stamp           = row_stamp;
      new_valid[line_way] = 1'b1;
      new_tag[line_way]   = tag_ff;
      new_stamp[line_way] = new_acc;
   end

   always_comb begin
      state_in     = state_ff;
      ways_in      = ways_ff;
      clr_cnt_in   = clr_cnt_ff;
      kind_in      = kind_ff;
      set_in       = set_ff;
      tag_in       = tag_ff;
      hit_in       = hit_ff;
      hit_way_in   = hit_way_ff;
      inv_in       = inv_ff;
      inv_way_in   = inv_way_ff;
      victim_in    = victim_ff;
      acc_in       = acc_ff;
      hit_tot_in   = hit_tot_ff;
      cold_tot_in  = cold_tot_ff;
      conf_tot_in  = conf_tot_ff;
      evict_tot_in = evict_tot_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      outcome_in   = outcome_ff;
      second_in    = second_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = set_ff;
      wr_row       = {new_stamp, new_tag, new_valid};

      if (csr_ch.valid) begin
         ways_in = csr_ch.ways_in_use;
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en      = 1'b1;
            wr_addr    = clr_cnt_ff;
            wr_row     = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AW'(NUM_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               rd_en    = 1'b1;
               kind_in  = kind_type'(req_ch.kind);
               set_in   = req_set;
               tag_in   = tag_ext[TAG_BITS-1:0];
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            hit_in     = hit_c;
            hit_way_in = hit_way_c;
            inv_in     = inv_c;
            inv_way_in = inv_way_c;
            state_in   = sel_start ? ST_SELECT : ST_FINISH;
         end
         ST_SELECT: begin
            if (sel_done) begin
               victim_in = sel_way;
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (push_ok) begin
               rsp_valid_in = 1'b1;
               second_in    = is_modify;
               state_in     = ST_IDLE;
               if (kind_ff == KIND_FETCH) begin
                  outcome_in = OUT_NONE;
               end else begin
                  wr_en      = 1'b1;
                  acc_in     = new_acc;
                  hit_tot_in = sat_add(hit_tot_ff, hit_inc);
                  if (hit_ff) begin
                     outcome_in = OUT_HIT;
                  end else if (inv_ff) begin
                     outcome_in  = OUT_COLD;
                     cold_tot_in = sat_add(cold_tot_ff, 2'd1);
                  end else begin
                     outcome_in   = OUT_CONFLICT;
                     conf_tot_in  = sat_add(conf_tot_ff, 2'd1);
                     evict_tot_in = sat_add(evict_tot_ff, 2'd1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ways_ff      <= WAYS_RESET;
         clr_cnt_ff   <= '0;
         acc_ff       <= '0;
         hit_tot_ff   <= '0;
         cold_tot_ff  <= '0;
         conf_tot_ff  <= '0;
         evict_tot_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ways_ff      <= ways_in;
         clr_cnt_ff   <= clr_cnt_in;
         acc_ff       <= acc_in;
         hit_tot_ff   <= hit_tot_in;
         cold_tot_ff  <= cold_tot_in;
         conf_tot_ff  <= conf_tot_in;
         evict_tot_ff <= evict_tot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff    <= kind_in;
      set_ff     <= set_in;
      tag_ff     <= tag_in;
      hit_ff     <= hit_in;
      hit_way_ff <= hit_way_in;
      inv_ff     <= inv_in;
      inv_way_ff <= inv_way_in;
      victim_ff  <= victim_in;
      outcome_ff <= outcome_in;
      second_ff  <= second_in;
   end

   salc_tag_ram #(
      .AW    (AW),
      .ROW_W (ROW_W)
   ) u_tag_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (req_set),
      .rd_data (rd_row),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_row)
   );

   assign req_ch.ready               = (state_ff == ST_IDLE);
   assign csr_ch.ready               = 1'b1;
   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.outcome             = outcome_ff;
   assign rsp_ch.second_hit          = second_ff;
   // Totals change only when a result beat is loaded, so they travel with it.
   assign rsp_ch.hit_total           = hit_tot_ff;
   assign rsp_ch.cold_miss_total     = cold_tot_ff;
   assign rsp_ch.conflict_miss_total = conf_tot_ff;
   assign rsp_ch.eviction_total      = evict_tot_ff;

endmodule

FILE: sv/salc_checker.sv
// Port-level checks for the LRU tag store, and the bind that attaches them.
// Depends on salc_pkg and on the top level's interface ports.
module salc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [salc_pkg::OUTCOME_W-1:0] outcome,
   input logic                           second_hit,
   input logic [salc_pkg::TOTAL_W-1:0]   hit_total,
   input logic [salc_pkg::TOTAL_W-1:0]   conflict_miss_total,
   input logic [salc_pkg::TOTAL_W-1:0]   eviction_total
);
   import salc_pkg::*;

   // Reset leaves no result beat pending.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // Every conflict miss evicts exactly one line, so the two totals track.
   a_evict_tracks: assert property (@(posedge clock) disable iff (reset)
      conflict_miss_total == eviction_total)
      else $error("eviction total differs from conflict miss total");

   // The saturating hit total never goes down outside reset.
   a_hit_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> hit_total >= $past(hit_total))
      else $error("hit total decreased");

   // A result that reports a hit already includes it in the hit total, so that total is not zero.
   a_hit_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (outcome == OUT_HIT || second_hit) |-> hit_total != '0)
      else $error("hit reported with zero hit total");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit_total) && $stable(outcome))
      else $error("stalled result beat changed");

endmodule

bind set_assoc_lru_cache_tag_model salc_checker u_salc_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .outcome             (rsp_ch.outcome),
   .second_hit          (rsp_ch.second_hit),
   .hit_total           (rsp_ch.hit_total),
   .conflict_miss_total (rsp_ch.conflict_miss_total),
   .eviction_total      (rsp_ch.eviction_total)
);

FILE: sim/tb_top.sv
// Self-checking testbench of the set-associative LRU tag store.
// Uses salc_pkg and the channel interfaces of salc_if.sv; a shadow tag store predicts
// every response beat, and random and directed accesses drive the request channel.
module tb_top;
   import salc_pkg::*;

   localparam int SET_COUNT       = 1 << SET_IDX_W;
   localparam int QUIET_LIMIT     = 4000;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int PHASE_ACCESSES  = 80;
   localparam int SETTLE_CYCLES   = 8;

   localparam int TOTAL_HIT      = 0;
   localparam int TOTAL_COLD     = 1;
   localparam int TOTAL_CONFLICT = 2;
   localparam int TOTAL_EVICT    = 3;

   typedef struct {
      outcome_type        outcome;
      logic               second_hit;
      logic [TOTAL_W-1:0] hits;
      logic [TOTAL_W-1:0] colds;
      logic [TOTAL_W-1:0] conflicts;
      logic [TOTAL_W-1:0] evictions;
   } access_result_type;

   class lru_tag_shadow_type;
      bit                  line_valid [SET_COUNT][DEF_WAYS];
      logic [TAG_W-1:0]    line_tag   [SET_COUNT][DEF_WAYS];
      logic [STAMP_W-1:0]  line_stamp [SET_COUNT][DEF_WAYS];
      logic [STAMP_W-1:0]  access_clock;
      logic [TOTAL_W-1:0]  totals [4];
      logic [WAYS_CFG_W-1:0] ways_cfg;
      access_result_type   expected_q [$];
      int                  mismatch_count;

      function new();
         foreach (line_valid[s, w]) line_valid[s][w] = 1'b0;
         foreach (totals[i]) totals[i] = '0;
         access_clock   = '0;
         ways_cfg       = WAYS_RESET;
         mismatch_count = 0;
      endfunction

      function void set_ways(logic [WAYS_CFG_W-1:0] v);
         ways_cfg = v;
      endfunction

      function void bump_total(int which);
         if (totals[which] != '1) totals[which] = totals[which] + 1'b1;
      endfunction

      function void note_access(kind_type k, logic [SET_IDX_W-1:0] s, logic [TAG_W-1:0] t);
         access_result_type  r;
         int                 used;
         int                 victim;
         int                 way;
         bit                 hit;
         bit                 have_invalid;
         bit                 have_valid;
         logic [STAMP_W-1:0] oldest;
         r.outcome    = OUT_NONE;
         r.second_hit = 1'b0;
         victim       = 0;
         way          = 0;
         hit          = 1'b0;
         have_invalid = 1'b0;
         have_valid   = 1'b0;
         oldest       = '0;
         if (k != KIND_FETCH) begin
            used = int'(ways_cfg);
            if (used < 1) used = 1;
            if (used > DEF_WAYS) used = DEF_WAYS;
            access_clock = access_clock + 1'b1;
            for (int i = 0; i < used && !hit; i++) begin
               if (line_valid[s][i]) begin
                  if (line_tag[s][i] == t) begin
                     hit = 1'b1;
                     way = i;
                  end else if (!have_valid || line_stamp[s][i] < oldest) begin
                     // An invalid way seen earlier keeps priority over the oldest line.
                     oldest = line_stamp[s][i];
                     if (!have_invalid) victim = i;
                     have_valid = 1'b1;
                  end
               end else begin
                  have_invalid = 1'b1;
                  victim       = i;
               end
            end
            if (hit) begin
               line_stamp[s][way] = access_clock;
               r.outcome = OUT_HIT;
               bump_total(TOTAL_HIT);
            end else begin
               way = victim;
               if (have_invalid) begin
                  r.outcome = OUT_COLD;
                  bump_total(TOTAL_COLD);
               end else begin
                  r.outcome = OUT_CONFLICT;
                  bump_total(TOTAL_CONFLICT);
                  bump_total(TOTAL_EVICT);
               end
               // The fill and the silent lookup after it each take a count, and the
               // line ends up stamped with the second one.
               access_clock       = access_clock + 2'd2;
               line_tag[s][way]   = t;
               line_valid[s][way] = 1'b1;
               line_stamp[s][way] = access_clock;
            end
            if (k == KIND_MODIFY) begin
               access_clock       = access_clock + 1'b1;
               line_stamp[s][way] = access_clock;
               bump_total(TOTAL_HIT);
               r.second_hit = 1'b1;
            end
         end
         r.hits      = totals[TOTAL_HIT];
         r.colds     = totals[TOTAL_COLD];
         r.conflicts = totals[TOTAL_CONFLICT];
         r.evictions = totals[TOTAL_EVICT];
         expected_q.push_back(r);
      endfunction

      function void compare_field(string name, logic [TOTAL_W-1:0] want,
                                  logic [TOTAL_W-1:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
         end
      endfunction

      function void check_response(access_result_type got);
         access_result_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: response beat with no access pending", $time);
            mismatch_count++;
            return;
         end
         want = expected_q.pop_front();
         compare_field("outcome", TOTAL_W'(want.outcome), TOTAL_W'(got.outcome));
         compare_field("second_hit", TOTAL_W'(want.second_hit), TOTAL_W'(got.second_hit));
         compare_field("hit_total", want.hits, got.hits);
         compare_field("cold_miss_total", want.colds, got.colds);
         compare_field("conflict_miss_total", want.conflicts, got.conflicts);
         compare_field("eviction_total", want.evictions, got.evictions);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   salc_req_if req_bus ();
   salc_rsp_if rsp_bus ();
   salc_csr_if csr_bus ();

   set_assoc_lru_cache_tag_model i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   lru_tag_shadow_type shadow = new();

   bit idling_on        = 1'b1;
   bit hold_off_request = 1'b0;

   logic [TAG_W-1:0]     tag_pool [12];
   logic [SET_IDX_W-1:0] set_pool [4];

   always #2 clock = ~clock;

   task automatic send_access(kind_type k, logic [SET_IDX_W-1:0] s, logic [TAG_W-1:0] t);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.kind      <= k;
      req_bus.set_index <= s;
      req_bus.tag       <= t;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      shadow.note_access(k, s, t);
   endtask

   // Lowers valid on the step of the last request beat, then waits out the responses.
   task automatic drain_and_settle();
      req_bus.valid <= 1'b0;
      while (shadow.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_ways(logic [WAYS_CFG_W-1:0] v);
      csr_bus.valid       <= 1'b1;
      csr_bus.ways_in_use <= v;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      csr_bus.valid <= 1'b0;
      shadow.set_ways(v);
   endtask

   task automatic pick_access(output kind_type k, output logic [SET_IDX_W-1:0] s,
                              output logic [TAG_W-1:0] t);
      if ($urandom_range(0, 9) == 0) k = KIND_FETCH;
      else k = kind_type'($urandom_range(1, 3));
      // Mostly a few hot sets and a small tag pool, so that lines refill and get evicted.
      if ($urandom_range(0, 3) == 0) s = SET_IDX_W'($urandom_range(0, SET_COUNT - 1));
      else s = set_pool[$urandom_range(0, 3)];
      if ($urandom_range(0, 6) == 0) t = TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
      else t = tag_pool[$urandom_range(0, 11)];
   endtask

   task automatic run_directed();
      send_access(KIND_FETCH,  0,  20'hFFFFF);
      send_access(KIND_LOAD,   0,  20'h00000);
      send_access(KIND_LOAD,   0,  20'h00000);
      send_access(KIND_STORE,  63, 20'hFFFFF);
      send_access(KIND_MODIFY, 63, 20'hFFFFF);
      send_access(KIND_MODIFY, 63, 20'h00001);
      send_access(KIND_FETCH,  63, 20'h00001);
      send_access(KIND_LOAD,   0,  20'hFFFFF);
      drain_and_settle();
      write_ways(4'd1);
      send_access(KIND_LOAD,   5,  20'h00007);
      send_access(KIND_LOAD,   5,  20'h00008);
      send_access(KIND_MODIFY, 5,  20'h00009);
      send_access(KIND_STORE,  5,  20'h00009);
      send_access(KIND_LOAD,   0,  20'h00000);
      drain_and_settle();
      // A way count of zero behaves as one, and one above the array as all ways.
      write_ways(4'd0);
      send_access(KIND_LOAD,   0,  20'h00000);
      send_access(KIND_STORE,  0,  20'h00005);
      drain_and_settle();
      write_ways(4'd15);
      send_access(KIND_LOAD,   0,  20'hFFFFF);
      send_access(KIND_LOAD,   0,  20'h00000);
      send_access(KIND_LOAD,   5,  20'h00009);
      drain_and_settle();
      write_ways(4'd2);
      send_access(KIND_LOAD,   9,  20'h0000A);
      send_access(KIND_LOAD,   9,  20'h0000B);
      send_access(KIND_LOAD,   9,  20'h0000A);
      send_access(KIND_LOAD,   9,  20'h0000C);
      send_access(KIND_LOAD,   9,  20'h0000A);
   endtask

   initial begin : response_side
      int                stall_left;
      access_result_type seen;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            seen.outcome    = outcome_type'(rsp_bus.outcome);
            seen.second_hit = rsp_bus.second_hit;
            seen.hits       = rsp_bus.hit_total;
            seen.colds      = rsp_bus.cold_miss_total;
            seen.conflicts  = rsp_bus.conflict_miss_total;
            seen.evictions  = rsp_bus.eviction_total;
            shadow.check_response(seen);
         end
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall_left = HOLD_OFF_CYCLES;
         end else if (stall_left == 0 && idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 9);
         end
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      logic [WAYS_CFG_W-1:0] ways_plan [9];
      int                    accesses;
      kind_type              k;
      logic [SET_IDX_W-1:0]  s;
      logic [TAG_W-1:0]      t;
      ways_plan = '{4'd1, 4'd15, 4'd0, 4'd3, 4'd9, 4'd2, 4'd5, 4'd4, 4'd8};
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.kind        <= KIND_FETCH;
      req_bus.set_index   <= '0;
      req_bus.tag         <= '0;
      csr_bus.valid       <= 1'b0;
      csr_bus.ways_in_use <= WAYS_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      foreach (ways_plan[p]) begin
         drain_and_settle();
         write_ways(ways_plan[p]);
         // The final phase runs both sides flat out.
         idling_on = (p != $size(ways_plan) - 1);
         if (p == 2) hold_off_request = 1'b1;
         foreach (tag_pool[i]) tag_pool[i] = TAG_W'($urandom_range(0, (1 << TAG_W) - 1));
         foreach (set_pool[i]) set_pool[i] = SET_IDX_W'($urandom_range(0, SET_COUNT - 1));
         accesses = 0;
         while (accesses < PHASE_ACCESSES) begin
            pick_access(k, s, t);
            send_access(k, s, t);
            if (k != KIND_FETCH) accesses++;
         end
      end
      drain_and_settle();
      if (shadow.mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: set_assoc_lru_cache_tag_model.f
sv/salc_pkg.sv
sv/salc_if.sv
sv/salc_tag_ram.sv
sv/salc_lru_sel.sv
sv/set_assoc_lru_cache_tag_model.sv
sv/salc_checker.sv
sim/tb_top.sv
